// ----- rtl/psr_pkg.sv -----
// psr_pkg: shared widths, constants, register codes and types for the pedal speed ramp
// depends on nothing; imported by every module of the block and by its checker
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 7;
    localparam int DRIVE_W    = 8;
    localparam int INTERVAL_W = 16;
    localparam int BAND_W     = 7;

    // averaging window, a power of two so the average is a plain shift
    localparam int WINDOW_LOG2 = 4;
    localparam int WINDOW      = 1 << WINDOW_LOG2;
    localparam int TOTAL_W     = SAMPLE_W + WINDOW_LOG2;

    // full scales
    localparam int PEDAL_FULL_SCALE = 4095;
    localparam int SPEED_FULL_SCALE = 100;
    localparam int DRIVE_FULL_SCALE = 255;

    // pedal to speed: avg*100 fits in this many bits, quotient by 4095 via a 12-bit shift
    localparam int SCALED_PEDAL_W = SAMPLE_W + SPEED_W;
    localparam int PEDAL_SHIFT    = 12;

    // speed to drive: (speed*255) * 5243 >> 19 equals speed*255/100 over the whole range
    localparam int DRIVE_SCALED_W = SPEED_W + DRIVE_W;
    localparam int DRIVE_RECIP    = 5243;
    localparam int DRIVE_RECIP_W  = 13;
    localparam int DRIVE_SHIFT    = 19;
    localparam int DRIVE_PROD_W   = DRIVE_SCALED_W + DRIVE_RECIP_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [INTERVAL_W-1:0] RST_ACCEL_SLOW   = INTERVAL_W'(40);
    localparam logic [INTERVAL_W-1:0] RST_ACCEL_MIDDLE = INTERVAL_W'(30);
    localparam logic [INTERVAL_W-1:0] RST_ACCEL_FAST   = INTERVAL_W'(20);
    localparam logic [INTERVAL_W-1:0] RST_BRAKE        = INTERVAL_W'(10);
    localparam logic [BAND_W-1:0]     RST_BAND_LOW     = BAND_W'(25);
    localparam logic [BAND_W-1:0]     RST_BAND_HIGH    = BAND_W'(80);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_SLOW   = 3'd0,
        REG_ACCEL_MIDDLE = 3'd1,
        REG_ACCEL_FAST   = 3'd2,
        REG_BRAKE        = 3'd3,
        REG_BAND_LOW     = 3'd4,
        REG_BAND_HIGH    = 3'd5
    } t_cfg_reg;

    // ramp settings handed to the ramp stage
    typedef struct packed {
        logic [INTERVAL_W-1:0] accel_slow;
        logic [INTERVAL_W-1:0] accel_middle;
        logic [INTERVAL_W-1:0] accel_fast;
        logic [INTERVAL_W-1:0] brake;
        logic [BAND_W-1:0]     band_low;
        logic [BAND_W-1:0]     band_high;
    } t_ramp_cfg;

    // drive level from a speed, speed*255/100 truncated
    function automatic logic [DRIVE_W-1:0] psr_drive(input logic [SPEED_W-1:0] speed);
        logic [DRIVE_SCALED_W-1:0] scaled;
        logic [DRIVE_PROD_W-1:0]   prod;
        scaled = {speed, DRIVE_W'(0)} - DRIVE_SCALED_W'(speed);
        prod   = DRIVE_PROD_W'(scaled) * DRIVE_PROD_W'(DRIVE_RECIP);
        return prod[DRIVE_SHIFT +: DRIVE_W];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/psr_cell.sv -----
// psr_cell: one sample cell of the averaging window shift line
// depends on psr_pkg for the sample width
`timescale 1ns / 1ps
`default_nettype none

module psr_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_shift,
    input  wire  [psr_pkg::SAMPLE_W-1:0] i_sample,
    output logic [psr_pkg::SAMPLE_W-1:0] o_sample
);
    import psr_pkg::*;

    logic [SAMPLE_W-1:0] r_sample;

    // take the neighbour's sample on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

// ----- rtl/psr_target.sv -----
// psr_target: pipeline stage mapping the window total to a target speed
// depends on psr_pkg for widths and scale constants
`timescale 1ns / 1ps
`default_nettype none

module psr_target (
    input  wire                         i_clk,
    input  wire                         i_load,
    input  wire  [psr_pkg::TOTAL_W-1:0] i_total,
    output logic [psr_pkg::SPEED_W-1:0] o_target
);
    import psr_pkg::*;

    logic [SAMPLE_W-1:0]       w_avg;
    logic [SCALED_PEDAL_W-1:0] w_scaled;
    logic [SPEED_W-1:0]        w_quot_lo;
    logic [PEDAL_SHIFT:0]      w_rem;
    logic                      w_corr;
    logic [SPEED_W-1:0]        r_target;
    logic [SPEED_W-1:0]        n_target;

    // avg*100/4095: divide by 4096 first, then at most one step of correction
    always_comb begin
        w_avg     = SAMPLE_W'(i_total >> WINDOW_LOG2);
        w_scaled  = SCALED_PEDAL_W'(w_avg) * SCALED_PEDAL_W'(SPEED_FULL_SCALE);
        w_quot_lo = w_scaled[PEDAL_SHIFT +: SPEED_W];
        w_rem     = (PEDAL_SHIFT + 1)'(w_scaled[PEDAL_SHIFT-1:0])
                  + (PEDAL_SHIFT + 1)'(w_quot_lo);
        w_corr    = (w_rem >= (PEDAL_SHIFT + 1)'(PEDAL_FULL_SCALE));
        n_target  = w_quot_lo + SPEED_W'(w_corr);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_target <= n_target;
        end
    end

    assign o_target = r_target;

endmodule

`default_nettype wire

// ----- rtl/psr_ramp.sv -----
// psr_ramp: slew-limited speed stage holding the ramped speed and last step time
// depends on psr_pkg for widths and the ramp settings struct
`timescale 1ns / 1ps
`default_nettype none

module psr_ramp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_load,
    input  wire  [psr_pkg::SPEED_W-1:0]  i_target,
    input  wire  [psr_pkg::TIME_W-1:0]   i_now,
    input  psr_pkg::t_ramp_cfg           i_cfg,
    output logic [psr_pkg::SPEED_W-1:0]  o_target,
    output logic [psr_pkg::SPEED_W-1:0]  o_speed
);
    import psr_pkg::*;

    logic [SPEED_W-1:0]    r_speed;
    logic [SPEED_W-1:0]    n_speed;
    logic [TIME_W-1:0]     r_last;
    logic [TIME_W-1:0]     n_last;
    logic [SPEED_W-1:0]    r_target;
    logic                  w_accel;
    logic [INTERVAL_W-1:0] w_interval;
    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_step;

    // interval choice, elapsed time check and one step toward the target
    always_comb begin
        w_accel = (r_speed < i_target);
        priority if (!w_accel) begin
            w_interval = i_cfg.brake;
        end else if (r_speed < i_cfg.band_low) begin
            w_interval = i_cfg.accel_slow;
        end else if (r_speed < i_cfg.band_high) begin
            w_interval = i_cfg.accel_middle;
        end else begin
            w_interval = i_cfg.accel_fast;
        end
        w_elapsed = i_now - r_last;
        w_step    = (w_elapsed >= TIME_W'(w_interval));
        n_speed   = r_speed;
        n_last    = r_last;
        if (w_step) begin
            n_last = i_now;
            if (w_accel) begin
                n_speed = r_speed + SPEED_W'(1);
            end else if (r_speed > i_target) begin
                n_speed = r_speed - SPEED_W'(1);
            end
        end
    end

    // ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_last  <= '0;
        end else if (i_load) begin
            r_speed <= n_speed;
            r_last  <= n_last;
        end
    end

    // target travels with the transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_target <= i_target;
        end
    end

    assign o_target = r_target;
    assign o_speed  = r_speed;

endmodule

`default_nettype wire

// ----- rtl/pedal_speed_ramp_core.sv -----
// pedal_speed_ramp_core: top level of the pedal filter and speed ramp
// depends on psr_pkg, psr_cell, psr_target and psr_ramp
//
// Usage
//   Input channel (i_in_valid / o_in_ready) takes one pedal sample and a millisecond
//   timestamp per transaction. Output channel (o_out_valid / i_out_ready) returns one
//   transaction per input: target speed, ramped speed and motor drive.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes one register per
//   transaction: 0 slow, 1 middle, 2 fast acceleration interval, 3 braking interval,
//   4 low and 5 high speed band; other indexes are ignored. It is always ready and
//   is meant to be used only while no transaction is in flight.
//   The result passes the window total, target, ramp and drive stages after the input
//   is taken. Throughput: one transaction per cycle while the receiver does not stall;
//   the ramp stage updates speed and last step time together, which allows that rate.
//   Reset (synchronous, active low) loads the register defaults, clears the window
//   cells, total, speed and last step time; the block is ready in the next cycle.
//   When the receiver stalls, the result holds and the stages behind it keep filling;
//   o_in_ready drops once all four stages hold transactions.
`timescale 1ns / 1ps
`default_nettype none

module pedal_speed_ramp_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [psr_pkg::SAMPLE_W-1:0]    i_pedal_sample,
    input  wire  [psr_pkg::TIME_W-1:0]      i_now_ms,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [psr_pkg::SPEED_W-1:0]     o_target_speed,
    output logic [psr_pkg::SPEED_W-1:0]     o_current_speed,
    output logic [psr_pkg::DRIVE_W-1:0]     o_motor_drive,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [psr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [psr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import psr_pkg::*;

    // configuration
    t_ramp_cfg r_cfg;

    // stage valids and readies
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_s1_ready, w_s2_ready, w_s3_ready, w_out_ready;
    logic w_accept;

    // window and total
    logic [SAMPLE_W-1:0] w_cell [WINDOW];
    logic [TOTAL_W-1:0]  r_total;
    logic [TOTAL_W-1:0]  n_total;

    // stage payloads
    logic [TIME_W-1:0]  r_s1_now;
    logic [TIME_W-1:0]  r_s2_now;
    logic [SPEED_W-1:0] w_s2_target;
    logic [SPEED_W-1:0] w_s3_target;
    logic [SPEED_W-1:0] w_s3_speed;
    logic [SPEED_W-1:0] r_out_target;
    logic [SPEED_W-1:0] r_out_speed;
    logic [DRIVE_W-1:0] r_out_drive;

    // configuration writes, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_slow   <= RST_ACCEL_SLOW;
            r_cfg.accel_middle <= RST_ACCEL_MIDDLE;
            r_cfg.accel_fast   <= RST_ACCEL_FAST;
            r_cfg.brake        <= RST_BRAKE;
            r_cfg.band_low     <= RST_BAND_LOW;
            r_cfg.band_high    <= RST_BAND_HIGH;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ACCEL_SLOW:   r_cfg.accel_slow   <= INTERVAL_W'(i_cfg_data);
                REG_ACCEL_MIDDLE: r_cfg.accel_middle <= INTERVAL_W'(i_cfg_data);
                REG_ACCEL_FAST:   r_cfg.accel_fast   <= INTERVAL_W'(i_cfg_data);
                REG_BRAKE:        r_cfg.brake        <= INTERVAL_W'(i_cfg_data);
                REG_BAND_LOW:     r_cfg.band_low     <= i_cfg_data[BAND_W-1:0];
                REG_BAND_HIGH:    r_cfg.band_high    <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // ready chain: a stage takes a transaction when empty or when it moves on
    always_comb begin
        w_out_ready = !r_out_valid || i_out_ready;
        w_s3_ready  = !r_s3_valid  || w_out_ready;
        w_s2_ready  = !r_s2_valid  || w_s3_ready;
        w_s1_ready  = !r_s1_valid  || w_s2_ready;
        o_in_ready  = w_s1_ready;
        w_accept    = i_in_valid && w_s1_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // window cells: the newest sample enters at the head, the oldest leaves at the tail
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            psr_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_accept),
                .i_sample (i_pedal_sample),
                .o_sample (w_cell[g])
            );
        end else begin : g_body
            psr_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_accept),
                .i_sample (w_cell[g-1]),
                .o_sample (w_cell[g])
            );
        end
    end

    // running total: add the new sample, drop the one leaving the window
    assign n_total = r_total - TOTAL_W'(w_cell[WINDOW-1]) + TOTAL_W'(i_pedal_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_accept) begin
            r_total <= n_total;
        end
    end

    // timestamp through the first two stages
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_now <= i_now_ms;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_s2_now <= r_s1_now;
        end
    end

    // target speed stage
    psr_target u_target (
        .i_clk    (i_clk),
        .i_load   (w_s2_ready && r_s1_valid),
        .i_total  (r_total),
        .o_target (w_s2_target)
    );

    // ramp stage
    psr_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_s3_ready && r_s2_valid),
        .i_target (w_s2_target),
        .i_now    (r_s2_now),
        .i_cfg    (r_cfg),
        .o_target (w_s3_target),
        .o_speed  (w_s3_speed)
    );

    // output register with drive level
    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s3_valid) begin
            r_out_target <= w_s3_target;
            r_out_speed  <= w_s3_speed;
            r_out_drive  <= psr_drive(w_s3_speed);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_target_speed  = r_out_target;
    assign o_current_speed = r_out_speed;
    assign o_motor_drive   = r_out_drive;

endmodule

`default_nettype wire

// ----- rtl/psr_checker.sv -----
// psr_checker: port-level assertions for pedal_speed_ramp_core, bound to the top level
// depends on psr_pkg for widths, scale constants and the drive function
`timescale 1ns / 1ps
`default_nettype none

module psr_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_out_valid,
    input wire                             i_out_ready,
    input wire  [psr_pkg::SPEED_W-1:0]     o_target_speed,
    input wire  [psr_pkg::SPEED_W-1:0]     o_current_speed,
    input wire  [psr_pkg::DRIVE_W-1:0]     o_motor_drive
);
    import psr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_current_speed)
            && $stable(o_target_speed) && $stable(o_motor_drive))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // drive level follows the reported speed
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_motor_drive == psr_drive(o_current_speed))
        else $error("drive level does not match speed");

    // speeds stay within full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_target_speed <= SPEED_W'(SPEED_FULL_SCALE)
            && o_current_speed <= SPEED_W'(SPEED_FULL_SCALE))
        else $error("speed above full scale");

endmodule

bind pedal_speed_ramp_core psr_checker u_psr_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for pedal_speed_ramp_core, a directed table then random phases
// checks every result against an in-bench speed predictor or a hand-written result; depends on psr_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import psr_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int DIRECTED_ROWS   = 24;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 48;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] speed;
        logic [DRIVE_W-1:0] drive;
    } t_speed_result;

    // one input transaction, with a hand-written result where typed is set
    typedef struct packed {
        logic [SAMPLE_W-1:0] pedal;
        logic [TIME_W-1:0]   now;
        logic                typed;
        t_speed_result       result;
    } t_pedal_txn;

    // register values for one random phase; spare also pokes the unmapped indexes
    typedef struct packed {
        logic [CFG_DATA_W-1:0] slow;
        logic [CFG_DATA_W-1:0] middle;
        logic [CFG_DATA_W-1:0] fast;
        logic [CFG_DATA_W-1:0] brake;
        logic [CFG_DATA_W-1:0] band_low;
        logic [CFG_DATA_W-1:0] band_high;
        logic                  spare;
    } t_ramp_setting;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_pedal_sample = '0;
    logic [TIME_W-1:0]     i_now_ms       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [SPEED_W-1:0]    o_target_speed;
    logic [SPEED_W-1:0]    o_current_speed;
    logic [DRIVE_W-1:0]    o_motor_drive;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    pedal_speed_ramp_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pedal_sample  (i_pedal_sample),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_target_speed  (o_target_speed),
        .o_current_speed (o_current_speed),
        .o_motor_drive   (o_motor_drive),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // directed stimulus, starting from the reset defaults
    t_pedal_txn pedal_table [DIRECTED_ROWS] = '{
        // idle pedal, nothing moves
        '{12'h000, 32'h0000_0000, 1'b1, '{7'd0, 7'd0, 8'd0}},
        // one full-scale sample, slow interval not yet reached
        '{12'hFFF, 32'h0000_0005, 1'b1, '{7'd6, 7'd0, 8'd0}},
        // fill the window at full scale, one slow interval apart
        '{12'hFFF, 32'd45,  1'b0, '0},
        '{12'hFFF, 32'd85,  1'b0, '0},
        '{12'hFFF, 32'd125, 1'b0, '0},
        '{12'hFFF, 32'd165, 1'b0, '0},
        '{12'hFFF, 32'd205, 1'b0, '0},
        '{12'hFFF, 32'd245, 1'b0, '0},
        '{12'hFFF, 32'd285, 1'b0, '0},
        '{12'hFFF, 32'd325, 1'b0, '0},
        '{12'hFFF, 32'd365, 1'b0, '0},
        '{12'hFFF, 32'd405, 1'b0, '0},
        '{12'hFFF, 32'd445, 1'b0, '0},
        '{12'hFFF, 32'd485, 1'b0, '0},
        '{12'hFFF, 32'd525, 1'b0, '0},
        '{12'hFFF, 32'd565, 1'b0, '0},
        '{12'hFFF, 32'd605, 1'b0, '0},
        // top of the time range, then a short and a long step across the wrap
        '{12'hFFF, 32'hFFFF_FFF0, 1'b0, '0},
        '{12'hFFF, 32'h0000_0004, 1'b0, '0},
        '{12'hFFF, 32'h0000_0030, 1'b0, '0},
        // timestamp going backwards reads as a very long gap
        '{12'h000, 32'h0000_0010, 1'b0, '0},
        // alternating bit patterns and mid scale
        '{12'h555, 32'h0000_1000, 1'b0, '0},
        '{12'hAAA, 32'h0000_2000, 1'b0, '0},
        '{12'h800, 32'h0000_2005, 1'b0, '0}
    };

    // register settings per random phase: defaults, zero intervals, widest intervals,
    // low band above high, bands above 100 and masked upper data bits
    t_ramp_setting ramp_settings [RANDOM_PHASES] = '{
        '{16'd40,    16'd30,    16'd20,    16'd10,    16'd25,    16'd80,    1'b1},
        '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b0},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd100,   16'd100,   1'b0},
        '{16'd5,     16'd3,     16'd1,     16'd2,     16'd100,   16'd0,     1'b0},
        '{16'd12,    16'd8,     16'd4,     16'd6,     16'hFF80,  16'h007F,  1'b1},
        '{16'd7,     16'd500,   16'd3,     16'd0,     16'hFFFF,  16'hFFFF,  1'b0},
        '{16'd1,     16'd2,     16'd3,     16'd4,     16'd10,    16'd50,    1'b0},
        '{16'd100,   16'd50,    16'd25,    16'd12,    16'h5555,  16'hAAAA,  1'b0},
        '{16'd40,    16'd30,    16'd20,    16'd10,    16'd25,    16'd80,    1'b1}
    };

    // predictor state
    logic [SAMPLE_W-1:0]    pedal_window [WINDOW];
    logic [TOTAL_W-1:0]     window_total;
    logic [WINDOW_LOG2-1:0] window_slot;
    logic [SPEED_W-1:0]     model_speed;
    logic [TIME_W-1:0]      model_step_ms;
    t_ramp_cfg              model_cfg;

    t_pedal_txn    pedal_feed_q [$];
    t_speed_result speed_expect_q [$];
    t_pedal_txn    inflight_txn = '0;
    logic [TIME_W-1:0] clock_ms = '0;
    int unsigned   tx_idle_pct  = 11;
    int unsigned   rx_idle_pct  = 78;
    int unsigned   fail_count   = 0;
    int unsigned   cycle_count  = 0;

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic reset_model();
        foreach (pedal_window[k]) pedal_window[k] = '0;
        window_total  = '0;
        window_slot   = '0;
        model_speed   = '0;
        model_step_ms = '0;
        model_cfg     = '{RST_ACCEL_SLOW, RST_ACCEL_MIDDLE, RST_ACCEL_FAST, RST_BRAKE,
                          RST_BAND_LOW, RST_BAND_HIGH};
    endtask

    // moving average, target mapping and one ramp step for an accepted sample
    function automatic t_speed_result predict_speed(input logic [SAMPLE_W-1:0] pedal,
                                                    input logic [TIME_W-1:0] now);
        logic [SAMPLE_W-1:0]   avg;
        logic [SPEED_W-1:0]    target;
        logic [INTERVAL_W-1:0] gap;
        logic [TIME_W-1:0]     elapsed;
        t_speed_result         res;
        window_total = window_total - TOTAL_W'(pedal_window[window_slot]) + TOTAL_W'(pedal);
        pedal_window[window_slot] = pedal;
        window_slot = window_slot + 1'b1;
        avg    = SAMPLE_W'(window_total / WINDOW);
        target = SPEED_W'((int'(avg) * SPEED_FULL_SCALE) / PEDAL_FULL_SCALE);

        // acceleration intervals only while below target
        if (model_speed < target) begin
            if (model_speed < model_cfg.band_low)
                gap = model_cfg.accel_slow;
            else if (model_speed < model_cfg.band_high)
                gap = model_cfg.accel_middle;
            else
                gap = model_cfg.accel_fast;
        end else begin
            gap = model_cfg.brake;
        end

        elapsed = now - model_step_ms;
        if (elapsed >= TIME_W'(gap)) begin
            model_step_ms = now;
            if (model_speed < target)
                model_speed = model_speed + 1'b1;
            else if (model_speed > target)
                model_speed = model_speed - 1'b1;
        end

        res.target = target;
        res.speed  = model_speed;
        res.drive  = DRIVE_W'((int'(model_speed) * DRIVE_FULL_SCALE) / SPEED_FULL_SCALE);
        return res;
    endfunction

    // one register write; valid is left high for a following write
    task automatic send_ramp_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ACCEL_SLOW:   model_cfg.accel_slow   = data;
            REG_ACCEL_MIDDLE: model_cfg.accel_middle = data;
            REG_ACCEL_FAST:   model_cfg.accel_fast   = data;
            REG_BRAKE:        model_cfg.brake        = data;
            REG_BAND_LOW:     model_cfg.band_low     = data[BAND_W-1:0];
            REG_BAND_HIGH:    model_cfg.band_high    = data[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_ramp_setting(input t_ramp_setting s);
        send_ramp_reg(REG_ACCEL_SLOW,   s.slow);
        send_ramp_reg(REG_ACCEL_MIDDLE, s.middle);
        send_ramp_reg(REG_ACCEL_FAST,   s.fast);
        send_ramp_reg(REG_BRAKE,        s.brake);
        send_ramp_reg(REG_BAND_LOW,     s.band_low);
        send_ramp_reg(REG_BAND_HIGH,    s.band_high);
        if (s.spare) begin
            send_ramp_reg(REG_SPARE_LO, 16'hFFFF);
            send_ramp_reg(REG_SPARE_HI, 16'h0000);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // runs of a held pedal level with jitter, stray readings and odd timestamps
    task automatic queue_pedal_runs(input int unsigned count, input int unsigned max_gap);
        int unsigned produced;
        int unsigned run_left;
        int unsigned level;
        t_pedal_txn  txn;
        produced = 0;
        while (produced < count) begin
            case ($urandom_range(9))
                0:       level = 0;
                1:       level = PEDAL_FULL_SCALE;
                default: level = $urandom_range(PEDAL_FULL_SCALE);
            endcase
            run_left = $urandom_range(24, 1);
            while (run_left > 0 && produced < count) begin
                txn = '0;
                if ($urandom_range(9) == 0)
                    txn.pedal = SAMPLE_W'($urandom_range(PEDAL_FULL_SCALE));
                else
                    txn.pedal = SAMPLE_W'(level) ^ SAMPLE_W'($urandom_range(7));
                case ($urandom_range(19))
                    0:       clock_ms = $urandom();
                    1:       clock_ms = clock_ms;
                    default: clock_ms = clock_ms + $urandom_range(max_gap);
                endcase
                txn.now = clock_ms;
                pedal_feed_q.push_back(txn);
                run_left--;
                produced++;
            end
        end
    endtask

    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pedal_feed_q.size() != 0 || i_in_valid || speed_expect_q.size() != 0);
    endtask

    // sender: predict on each accepted transaction, then offer the next one
    always @(posedge i_clk) begin : feed_side
        t_pedal_txn    txn;
        t_speed_result predicted;
        if (i_in_valid && o_in_ready) begin
            predicted = predict_speed(i_pedal_sample, i_now_ms);
            if (inflight_txn.typed)
                speed_expect_q.push_back(inflight_txn.result);
            else
                speed_expect_q.push_back(predicted);
        end
        if (!i_in_valid || o_in_ready) begin
            if (pedal_feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                txn = pedal_feed_q.pop_front();
                i_in_valid     <= 1'b1;
                i_pedal_sample <= txn.pedal;
                i_now_ms       <= txn.now;
                inflight_txn   <= txn;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : drain_side
        t_speed_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (speed_expect_q.size() == 0) begin
                $display("%0t: unexpected result target %0d speed %0d drive %0d",
                         $time, o_target_speed, o_current_speed, o_motor_drive);
                fail_count++;
            end else begin
                want = speed_expect_q.pop_front();
                if (o_target_speed !== want.target) begin
                    $display("%0t: target_speed expected %0d got %0d",
                             $time, want.target, o_target_speed);
                    fail_count++;
                end
                if (o_current_speed !== want.speed) begin
                    $display("%0t: current_speed expected %0d got %0d",
                             $time, want.speed, o_current_speed);
                    fail_count++;
                end
                if (o_motor_drive !== want.drive) begin
                    $display("%0t: motor_drive expected %0d got %0d",
                             $time, want.drive, o_motor_drive);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_plan
        int unsigned widest;
        int unsigned max_gap;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        @(negedge i_clk);
        foreach (pedal_table[r]) pedal_feed_q.push_back(pedal_table[r]);
        wait_until_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // sender mostly sending and receiver busy, then swapped, then no idling
            if (p < 3) begin
                tx_idle_pct = 11;
                rx_idle_pct = 78;
            end else if (p < 6) begin
                tx_idle_pct = 78;
                rx_idle_pct = 11;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            load_ramp_setting(ramp_settings[p]);

            // timestamp steps around the widest interval so ramps both step and wait
            widest = ramp_settings[p].slow;
            if (ramp_settings[p].middle > widest) widest = ramp_settings[p].middle;
            if (ramp_settings[p].fast > widest) widest = ramp_settings[p].fast;
            if (ramp_settings[p].brake > widest) widest = ramp_settings[p].brake;
            max_gap = 2 * widest + 4;
            @(negedge i_clk);
            if (p % 3 == 1) clock_ms = 32'hFFFF_FFFF - TIME_W'(max_gap * 8);

            // first half, then let every result come home before the second half
            queue_pedal_runs(ITEMS_PER_PHASE / 2, max_gap);
            wait_until_drained();
            queue_pedal_runs(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2, max_gap);
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
